### src/ple_pkg.sv
// shared types and constants for the positional list engine
// depends on nothing; used by ple_cell and positional_list_engine_top
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_READ      = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          target;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic                      valid;
        logic signed [DATA_W-1:0]  data;
    } cell_data_t;

endpackage

### src/ple_cell.sv
// one storage cell of the list chain: holds one element in list order
// depends on ple_pkg (cell_ctrl_t, cell_data_t, cell_op_t)
module ple_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ple_pkg::IDX_W-1:0]    cell_idx,
    input  ple_pkg::cell_ctrl_t          ctrl,
    input  ple_pkg::cell_data_t          left,
    input  ple_pkg::cell_data_t          right,
    input  logic signed [ple_pkg::DATA_W-1:0] wrap,
    output ple_pkg::cell_data_t          q
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [ple_pkg::DATA_W-1:0]  data_reg;
    logic signed [ple_pkg::DATA_W-1:0]  data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (ctrl.op)
            ple_pkg::CELL_INSERT:
            begin
                if (cell_idx == ctrl.target)
                begin
                    valid_next = 1'b1;
                    data_next  = ctrl.value;
                end
                else if (cell_idx > ctrl.target)
                begin
                    valid_next = left.valid;
                    data_next  = left.data;
                end
            end
            ple_pkg::CELL_DELETE:
            begin
                if (cell_idx >= ctrl.target)
                begin
                    valid_next = right.valid;
                    data_next  = right.data;
                end
            end
            ple_pkg::CELL_ROTATE:
            begin
                // tail cell takes the head value, others take their right neighbor
                if (valid_reg)
                    data_next = right.valid ? right.data : wrap;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q.valid = valid_reg;
    assign q.data  = data_reg;

endmodule

### src/positional_list_engine_top.sv
// top level of the positional list engine: command decode, read-out sequencer
// depends on ple_pkg and ple_cell
//
// Bounded ordered list of up to ple_pkg::CAPACITY signed 32-bit elements. A command
// beat is taken when start is high and busy is low. Every update (insert or delete
// at front, back or a 1-based position) answers with exactly one result beat, with
// result_strobe high, on the cycle right after the accepting edge; busy stays low so
// a new command can be taken every cycle. A read-out of a list of n elements raises
// busy until it is done and gives n result beats on consecutive cycles, each the head
// of the chain registered during the read state, the last one marked by last; an empty
// list gives one empty status beat on the cycle after the accepting edge instead.
// During a read-out the chain rotates one element past the head per cycle. The
// receiver cannot stall: each result beat is on the ports for one cycle only. Mode
// seven is ignored and gives no beat.
module positional_list_engine_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            mode,
    input  logic signed [ple_pkg::DATA_W-1:0]     value,
    input  logic [ple_pkg::POS_W-1:0]             position,
    output logic                                  result_strobe,
    output logic signed [ple_pkg::DATA_W-1:0]     element,
    output logic [1:0]                            status,
    output logic                                  last
);

    // control state
    ple_pkg::state_t                    state_reg;
    ple_pkg::state_t                    state_next;
    logic [ple_pkg::CNT_W-1:0]          count_reg;
    logic [ple_pkg::CNT_W-1:0]          count_next;
    logic [ple_pkg::CNT_W-1:0]          rd_left_reg;
    logic [ple_pkg::CNT_W-1:0]          rd_left_next;

    // result register
    logic                               strobe_reg;
    logic                               strobe_next;
    logic signed [ple_pkg::DATA_W-1:0]  element_reg;
    logic signed [ple_pkg::DATA_W-1:0]  element_next;
    ple_pkg::status_t                   status_reg;
    ple_pkg::status_t                   status_next;
    logic                               last_reg;
    logic                               last_next;

    // chain
    ple_pkg::cell_ctrl_t                cell_ctrl;
    ple_pkg::cell_data_t                cell_q [ple_pkg::CAPACITY];

    // decode helpers
    logic                               accept;
    logic                               full;
    logic                               empty;
    logic [ple_pkg::CMP_W-1:0]          pos_ext;
    logic [ple_pkg::CMP_W-1:0]          cnt_ext;
    logic [ple_pkg::CMP_W-1:0]          pos_m1;
    logic [ple_pkg::CMP_W-1:0]          cnt_m1;
    logic                               pos_zero;
    logic                               ins_pos_bad;
    logic                               del_pos_bad;

    assign busy    = (state_reg == ple_pkg::S_READ);
    assign accept  = start && !busy;
    assign full    = (count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = ple_pkg::CMP_W'(position);
    assign cnt_ext = ple_pkg::CMP_W'(count_reg);
    assign pos_m1  = pos_ext - ple_pkg::CMP_W'(1);
    assign cnt_m1  = cnt_ext - ple_pkg::CMP_W'(1);
    assign pos_zero    = (position == '0);
    // insert accepts positions 1 .. count+1, delete 1 .. count
    assign ins_pos_bad = pos_zero || (pos_ext > cnt_ext + ple_pkg::CMP_W'(1));
    assign del_pos_bad = pos_zero || (pos_ext > cnt_ext);

    // next state of the read-out sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_left_next = rd_left_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept && (mode == ple_pkg::MODE_READ) && !empty)
                begin
                    state_next   = ple_pkg::S_READ;
                    rd_left_next = count_reg;
                end
            end
            ple_pkg::S_READ:
            begin
                rd_left_next = rd_left_reg - ple_pkg::CNT_W'(1);
                if (rd_left_reg == ple_pkg::CNT_W'(1))
                    state_next = ple_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    // chain command, element count and result beat
    always_comb
    begin
        cell_ctrl.op     = ple_pkg::CELL_HOLD;
        cell_ctrl.target = '0;
        cell_ctrl.value  = value;
        count_next       = count_reg;
        strobe_next      = 1'b0;
        element_next     = '0;
        status_next      = ple_pkg::ST_OK;
        last_next        = 1'b1;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (ple_pkg::mode_t'(mode))
                        ple_pkg::MODE_INS_FRONT:
                        begin
                            if (full)
                                status_next = ple_pkg::ST_FULL;
                            else
                            begin
                                cell_ctrl.op = ple_pkg::CELL_INSERT;
                                count_next   = count_reg + ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_INS_BACK:
                        begin
                            if (full)
                                status_next = ple_pkg::ST_FULL;
                            else
                            begin
                                cell_ctrl.op     = ple_pkg::CELL_INSERT;
                                cell_ctrl.target = cnt_ext[ple_pkg::IDX_W-1:0];
                                count_next       = count_reg + ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_INS_POS:
                        begin
                            if (ins_pos_bad)
                                status_next = ple_pkg::ST_BADPOS;
                            else if (full)
                                status_next = ple_pkg::ST_FULL;
                            else
                            begin
                                cell_ctrl.op     = ple_pkg::CELL_INSERT;
                                cell_ctrl.target = pos_m1[ple_pkg::IDX_W-1:0];
                                count_next       = count_reg + ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_DEL_FRONT:
                        begin
                            if (empty)
                                status_next = ple_pkg::ST_EMPTY;
                            else
                            begin
                                cell_ctrl.op = ple_pkg::CELL_DELETE;
                                count_next   = count_reg - ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_DEL_BACK:
                        begin
                            if (empty)
                                status_next = ple_pkg::ST_EMPTY;
                            else
                            begin
                                cell_ctrl.op     = ple_pkg::CELL_DELETE;
                                cell_ctrl.target = cnt_m1[ple_pkg::IDX_W-1:0];
                                count_next       = count_reg - ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_DEL_POS:
                        begin
                            if (empty)
                                status_next = ple_pkg::ST_EMPTY;
                            else if (del_pos_bad)
                                status_next = ple_pkg::ST_BADPOS;
                            else
                            begin
                                cell_ctrl.op     = ple_pkg::CELL_DELETE;
                                cell_ctrl.target = pos_m1[ple_pkg::IDX_W-1:0];
                                count_next       = count_reg - ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::MODE_READ:
                        begin
                            // a non-empty list answers from the read state instead
                            if (empty)
                                status_next = ple_pkg::ST_EMPTY;
                            else
                                strobe_next = 1'b0;
                        end
                        default:
                        begin
                            // reserved mode: no beat
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            ple_pkg::S_READ:
            begin
                // head goes out, chain rotates so the next element reaches the head
                cell_ctrl.op = ple_pkg::CELL_ROTATE;
                strobe_next  = 1'b1;
                element_next = cell_q[0].data;
                last_next    = (rd_left_reg == ple_pkg::CNT_W'(1));
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ple_pkg::S_IDLE;
            count_reg   <= '0;
            rd_left_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_left_reg <= rd_left_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg <= element_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    // row of cells, cell 0 is the head of the list
    genvar g;
    generate
        for (g = 0; g < ple_pkg::CAPACITY; g++)
        begin : g_cell
            ple_pkg::cell_data_t left_d;
            ple_pkg::cell_data_t right_d;

            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[g-1];
            end

            if (g == ple_pkg::CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[g+1];
            end

            ple_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (ple_pkg::IDX_W'(g)),
                .ctrl     (cell_ctrl),
                .left     (left_d),
                .right    (right_d),
                .wrap     (cell_q[0].data),
                .q        (cell_q[g])
            );
        end
    endgenerate

    assign result_strobe = strobe_reg;
    assign element       = element_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule
